// File: rtl/core/fctc_pkg.sv
// Package: shared constants and types for the floor/ceiling texel caster.
`timescale 1ns / 1ps
`default_nettype none
package fctc_pkg;
  localparam int FLOOR_TEX_W = 64;
  localparam int FLOOR_TEX_H = 64;
  localparam int CEIL_TEX_W = 64;
  localparam int CEIL_TEX_H = 64;
  localparam int DIV_BITS = 28;

  localparam logic [2:0] REG_CAM_X = 3'd0;
  localparam logic [2:0] REG_CAM_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X = 3'd2;
  localparam logic [2:0] REG_DIR_Y = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_WIDTH = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  // Commands from controller to datapath
  typedef struct packed {
    logic div_start;   // load the row-distance divider
    logic div_step;    // one quotient bit
    logic mul_dist;    // latch distance, form ray terms
    logic ste_start;   // compute products, then load step dividers
    logic ste_step;    // one quotient bit of step dividers
    logic row_commit;  // write steps, world start, row
    logic pix;         // emit pixel into output register, advance
  } fctc_cmd_t;

  typedef struct packed {
    logic row_ok;      // row start is a valid lower-half row
    logic pix_ok;      // a column remains
  } fctc_stat_t;

  // Texture coordinate: 0 for negative, else (size*frac)>>16 clamped
  function automatic logic [9:0] tex_coord(input logic [31:0] f, input int size);
    logic [25:0] t;
    t = 26'(size) * {10'd0, f[15:0]};
    if (f[31]) return 10'd0;
    if (t[25:16] > 10'(size - 1)) return 10'(size - 1);
    return t[25:16];
  endfunction

  function automatic logic [11:0] texel(input logic [31:0] wx, input logic [31:0] wy,
                                        input int w, input int h);
    logic [21:0] p;
    p = 22'(tex_coord(wx, h)) * 22'(w) + 22'(tex_coord(wy, w));
    return p[11:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/fctc_if.sv
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface fctc_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [10:0] row;
  modport source (output valid, action, row, input ready);
  modport sink (input valid, action, row, output ready);
endinterface

interface fctc_out_if;
  logic valid;
  logic ready;
  logic [10:0] column;
  logic [10:0] floor_row;
  logic [10:0] ceiling_row;
  logic [11:0] floor_texel;
  logic [11:0] ceiling_texel;
  logic last_in_row;
  modport source (output valid, column, floor_row, ceiling_row, floor_texel,
                  ceiling_texel, last_in_row, input ready);
  modport sink (input valid, column, floor_row, ceiling_row, floor_texel,
                ceiling_texel, last_in_row, output ready);
endinterface

interface fctc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fctc_datapath.sv
// Datapath: config registers, dividers, row state and pixel texel math.
`timescale 1ns / 1ps
`default_nettype none
module fctc_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [10:0]         in_row,
  input  wire fctc_pkg::fctc_cmd_t cmd,
  output fctc_pkg::fctc_stat_t     stat,
  output logic [10:0]              column,
  output logic [10:0]              floor_row,
  output logic [10:0]              ceiling_row,
  output logic [11:0]              floor_texel,
  output logic [11:0]              ceiling_texel,
  output logic                     last_in_row
);
  logic [31:0] cam_x, cam_y;
  logic [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [11:0] width, height;
  logic [31:0] world_x, world_y, step_x, step_y;
  logic [10:0] active_row, pend_row;
  logic [11:0] next_column;

  // Distance divider: (H<<16)/den, restoring, one bit per cycle
  logic [27:0] dq;
  logic [12:0] dr;
  logic [11:0] dden;
  logic [13:0] dtrial;
  logic [27:0] row_dist;

  // Products
  logic signed [17:0] r0x, r0y, dlx, dly;
  logic signed [46:0] pdx, pdy, p0x, p0y;
  // Step dividers on magnitudes: |p| / (W<<14)
  logic [45:0] sqx, sqy;
  logic [26:0] srx, sry;
  logic sgx, sgy;
  logic [27:0] tx, ty;
  logic [25:0] sden;
  logic load_mag;
  logic [45:0] magx, magy;

  logic [11:0] h2row;
  assign h2row = {in_row, 1'b0} - height;
  assign stat.row_ok = ({1'b0, in_row} < height) && ({in_row, 1'b0} > height);
  assign stat.pix_ok = next_column < width;

  assign dtrial = {dr, dq[27]} - {2'b0, dden};
  assign sden = {width, 14'd0};
  assign tx = {srx, sqx[45]} - {2'b0, sden};
  assign ty = {sry, sqy[45]} - {2'b0, sden};

  logic [31:0] world_x_adv, world_y_adv;
  assign world_x_adv = world_x + step_x;
  assign world_y_adv = world_y + step_y;

  // Configuration writes and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0; cam_y <= '0;
      dir_x <= '0; dir_y <= '0; plane_x <= '0; plane_y <= '0;
      width <= 12'd640; height <= 12'd480;
      world_x <= '0; world_y <= '0; step_x <= '0; step_y <= '0;
      active_row <= '0; next_column <= 12'd640;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fctc_pkg::REG_CAM_X: cam_x <= cfg_data;
          fctc_pkg::REG_CAM_Y: cam_y <= cfg_data;
          fctc_pkg::REG_DIR_X: dir_x <= cfg_data[15:0];
          fctc_pkg::REG_DIR_Y: dir_y <= cfg_data[15:0];
          fctc_pkg::REG_PLANE_X: plane_x <= cfg_data[15:0];
          fctc_pkg::REG_PLANE_Y: plane_y <= cfg_data[15:0];
          fctc_pkg::REG_WIDTH: begin
            width <= cfg_data[11:0];
            next_column <= cfg_data[11:0];
          end
          fctc_pkg::REG_HEIGHT: next_column <= width;
          default: ;
        endcase
        if (cfg_index == fctc_pkg::REG_HEIGHT) height <= cfg_data[11:0];
      end
      if (cmd.row_commit) begin
        step_x <= (width == 12'd0) ? 32'd0 :
                  (sgx ? 32'(-sqx) : sqx[31:0]);
        step_y <= (width == 12'd0) ? 32'd0 :
                  (sgy ? 32'(-sqy) : sqy[31:0]);
        world_x <= cam_x + 32'(p0x >>> 14) + ((p0x < 0 && p0x[13:0] != 0) ? 32'd1 : 32'd0);
        world_y <= cam_y + 32'(p0y >>> 14) + ((p0y < 0 && p0y[13:0] != 0) ? 32'd1 : 32'd0);
        active_row <= pend_row;
        next_column <= '0;
      end
      if (cmd.pix) begin
        world_x <= world_x_adv;
        world_y <= world_y_adv;
        next_column <= next_column + 12'd1;
      end
    end
  end

  // Row-start arithmetic
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq <= {height, 16'd0};
      dr <= '0;
      dden <= h2row;
      pend_row <= in_row;
    end else if (cmd.div_step) begin
      if (!dtrial[13]) begin
        dr <= dtrial[12:0];
        dq <= {dq[26:0], 1'b1};
      end else begin
        dr <= {dr[11:0], dq[27]};
        dq <= {dq[26:0], 1'b0};
      end
    end
    if (cmd.mul_dist) begin
      row_dist <= dq;
      r0x <= 18'(signed'(dir_x)) + 18'(signed'(plane_x));
      r0y <= 18'(signed'(dir_y)) + 18'(signed'(plane_y));
      dlx <= -(18'(signed'(plane_x)) <<< 1);
      dly <= -(18'(signed'(plane_y)) <<< 1);
    end
    if (cmd.ste_start) begin
      pdx <= signed'({19'd0, row_dist}) * 47'(dlx);
      pdy <= signed'({19'd0, row_dist}) * 47'(dly);
      p0x <= signed'({19'd0, row_dist}) * 47'(r0x);
      p0y <= signed'({19'd0, row_dist}) * 47'(r0y);
    end
    // Load magnitudes and signs, then one quotient bit per step
    if (load_mag) begin
      sqx <= magx; sqy <= magy;
      srx <= '0; sry <= '0;
      sgx <= pdx[46];
      sgy <= pdy[46];
    end else if (cmd.ste_step) begin
      if (!tx[27]) begin srx <= tx[26:0]; sqx <= {sqx[44:0], 1'b1}; end
      else begin srx <= {srx[25:0], sqx[45]}; sqx <= {sqx[44:0], 1'b0}; end
      if (!ty[27]) begin sry <= ty[26:0]; sqy <= {sqy[44:0], 1'b1}; end
      else begin sry <= {sry[25:0], sqy[45]}; sqy <= {sqy[44:0], 1'b0}; end
    end
  end

  // Magnitude loading happens in the cycle after the products land
  always_ff @(posedge clk) begin
    if (rst) load_mag <= 1'b0;
    else load_mag <= cmd.ste_start;
  end

  assign magx = pdx[46] ? 46'(-pdx) : pdx[45:0];
  assign magy = pdy[46] ? 46'(-pdy) : pdy[45:0];

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.pix) begin
      column <= next_column[10:0];
      floor_row <= active_row;
      ceiling_row <= 11'(height - {1'b0, active_row} - 12'd1);
      floor_texel <= fctc_pkg::texel(world_x, world_y, fctc_pkg::FLOOR_TEX_W,
                                     fctc_pkg::FLOOR_TEX_H);
      ceiling_texel <= fctc_pkg::texel(world_x_adv, world_y_adv, fctc_pkg::CEIL_TEX_W,
                                       fctc_pkg::CEIL_TEX_H);
      last_in_row <= next_column == width - 12'd1;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/fctc_ctrl.sv
// Controller: sequences row starts and pixel beats.
`timescale 1ns / 1ps
`default_nettype none
module fctc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_action,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire fctc_pkg::fctc_stat_t stat,
  output fctc_pkg::fctc_cmd_t       cmd
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_PROD   = 3'd3;
  localparam logic [2:0] S_STEP   = 3'd4;
  localparam logic [2:0] S_SIGN   = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] count, count_next;
  logic out_valid_next;
  logic take;

  // Output slot frees when taken; pixels flow back to back
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (take && in_action && stat.pix_ok) begin
          cmd.pix = 1'b1;
          out_valid_next = 1'b1;
        end else if (take && !in_action && stat.row_ok) begin
          cmd.div_start = 1'b1;
          count_next = 6'd27;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        count_next = count - 6'd1;
        if (count == 6'd0) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_dist = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.ste_start = 1'b1;
        state_next = S_SIGN;
      end
      S_SIGN: begin
        count_next = 6'd45;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.ste_step = 1'b1;
        count_next = count - 6'd1;
        if (count == 6'd0) state_next = S_COMMIT;
      end
      // Quotients are final here
      S_COMMIT: begin
        cmd.row_commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/floor_ceiling_texel_caster.sv
// Top level: floor and ceiling texel caster.
// A pixel-step beat produces its result in the output register in the cycle
// after it is taken, and beats flow one per clock while the output is taken.
// A valid row start keeps the input closed after its beat, through the
// row-distance division, the products and magnitude loading, the two
// parallel step dividers and the commit.
// Invalid rows and excess steps are consumed without results.
`timescale 1ns / 1ps
`default_nettype none
module floor_ceiling_texel_caster (
  input  wire logic   clk,
  input  wire logic   rst,
  fctc_cfg_if.sink    cfg,
  fctc_in_if.sink     in_ch,
  fctc_out_if.source  out_ch
);
  fctc_pkg::fctc_cmd_t cmd;
  fctc_pkg::fctc_stat_t stat;
  logic busy_n;

  assign cfg.ready = 1'b1;
  assign busy_n = 1'b1;

  fctc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_action(in_ch.action), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready & busy_n),
    .stat(stat), .cmd(cmd)
  );

  fctc_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .in_row(in_ch.row), .cmd(cmd), .stat(stat),
    .column(out_ch.column), .floor_row(out_ch.floor_row),
    .ceiling_row(out_ch.ceiling_row), .floor_texel(out_ch.floor_texel),
    .ceiling_texel(out_ch.ceiling_texel), .last_in_row(out_ch.last_in_row)
  );
endmodule
`default_nettype wire

// File: sim/floor_ceiling_texel_caster_tb.sv
// Testbench: floor/ceiling texel caster checked against a fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none
module floor_ceiling_texel_caster_tb;
  localparam logic ACT_ROW = 1'b0;
  localparam logic ACT_PIX = 1'b1;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] floor_row;
    logic [10:0] ceiling_row;
    logic [11:0] floor_texel;
    logic [11:0] ceiling_texel;
    logic        last_in_row;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  longint cycles = 0;
  bit   out_steady = 0;

  fctc_cfg_if cfg ();
  fctc_in_if  in_ch ();
  fctc_out_if out_ch ();

  floor_ceiling_texel_caster dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Texture coordinate from one Q16.16 world value
  function automatic int unsigned tcoord(input logic [31:0] f, input int unsigned size);
    int unsigned t;
    if (f[31]) return 0;
    t = (size * f[15:0]) >> 16;
    return (t > size - 1) ? size - 1 : t;
  endfunction

  function automatic logic [11:0] tex_index(input logic [31:0] wx, input logic [31:0] wy,
                                            input int unsigned w, input int unsigned h);
    int unsigned u, v;
    u = tcoord(wy, w);
    v = tcoord(wx, h);
    return 12'(v * w + u);
  endfunction

  class pixel_scoreboard;
    logic [31:0] cam_x, cam_y;
    logic [15:0] dir_x, dir_y, pl_x, pl_y;
    logic [11:0] width, height;
    logic [31:0] wx, wy, sx, sy;
    logic [10:0] cur_row;
    logic [11:0] next_col;
    pixel_t pending[$];

    function new();
      cam_x = 0; cam_y = 0; dir_x = 0; dir_y = 0; pl_x = 0; pl_y = 0;
      width = 640; height = 480;
      wx = 0; wy = 0; sx = 0; sy = 0; cur_row = 0; next_col = 640;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [31:0] d);
      case (idx)
        fctc_pkg::REG_CAM_X:   cam_x = d;
        fctc_pkg::REG_CAM_Y:   cam_y = d;
        fctc_pkg::REG_DIR_X:   dir_x = d[15:0];
        fctc_pkg::REG_DIR_Y:   dir_y = d[15:0];
        fctc_pkg::REG_PLANE_X: pl_x = d[15:0];
        fctc_pkg::REG_PLANE_Y: pl_y = d[15:0];
        fctc_pkg::REG_WIDTH:   begin width = d[11:0]; next_col = d[11:0]; end
        fctc_pkg::REG_HEIGHT:  begin height = d[11:0]; next_col = width; end
        default: ;
      endcase
    endfunction

    // Note an accepted item: a valid row start recomputes the walk, a pixel step with a column left predicts one beat
    function void note_item(input logic act, input logic [10:0] r);
      longint row_dist, r0x, r0y, r1x, r1y, dv;
      pixel_t p;
      if (act == ACT_ROW) begin
        if (r >= height || 2 * r <= height) return;
        row_dist = (longint'(height) << 16) / (2 * r - height);
        r0x = longint'($signed(dir_x)) + $signed(pl_x);
        r0y = longint'($signed(dir_y)) + $signed(pl_y);
        r1x = longint'($signed(dir_x)) - $signed(pl_x);
        r1y = longint'($signed(dir_y)) - $signed(pl_y);
        if (width != 0) begin
          dv = longint'(width) * 16384;
          sx = 32'((row_dist * (r1x - r0x)) / dv);
          sy = 32'((row_dist * (r1y - r0y)) / dv);
        end else begin
          sx = 0; sy = 0;
        end
        wx = 32'(longint'($signed(cam_x)) + (row_dist * r0x) / 16384);
        wy = 32'(longint'($signed(cam_y)) + (row_dist * r0y) / 16384);
        cur_row = r;
        next_col = 0;
        return;
      end
      if (next_col >= width) return;
      p.column = next_col[10:0];
      p.floor_row = cur_row;
      p.ceiling_row = 11'(height - cur_row - 1);
      p.floor_texel = tex_index(wx, wy, fctc_pkg::FLOOR_TEX_W, fctc_pkg::FLOOR_TEX_H);
      wx += sx;
      wy += sy;
      p.ceiling_texel = tex_index(wx, wy, fctc_pkg::CEIL_TEX_W, fctc_pkg::CEIL_TEX_H);
      p.last_in_row = (next_col == width - 1);
      next_col = next_col + 1;
      pending.push_back(p);
    endfunction

    task check_beat(input pixel_t got);
      pixel_t w;
      if (pending.size() == 0) begin
        report("unexpected beat column", 32'(got.column), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.column != w.column) report("column", 32'(got.column), 32'(w.column));
      if (got.floor_row != w.floor_row)
        report("floor_row", 32'(got.floor_row), 32'(w.floor_row));
      if (got.ceiling_row != w.ceiling_row)
        report("ceiling_row", 32'(got.ceiling_row), 32'(w.ceiling_row));
      if (got.floor_texel != w.floor_texel)
        report("floor_texel", 32'(got.floor_texel), 32'(w.floor_texel));
      if (got.ceiling_texel != w.ceiling_texel)
        report("ceiling_texel", 32'(got.ceiling_texel), 32'(w.ceiling_texel));
      if (got.last_in_row != w.last_in_row)
        report("last_in_row", 32'(got.last_in_row), 32'(w.last_in_row));
    endtask
  endclass

  pixel_scoreboard sb = new();

  initial begin
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    in_ch.valid = 0; in_ch.action = 0; in_ch.row = 0;
    out_ch.ready = 0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("floor_ceiling_texel_caster_tb failed");
      $finish;
    end
  end

  // Result side: random stalls, monitor on accepted beats
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.column, out_ch.floor_row, out_ch.ceiling_row,
                     out_ch.floor_texel, out_ch.ceiling_texel, out_ch.last_in_row});
    out_ch.ready <= rst ? 1'b0 : (out_steady || $urandom_range(99) >= 16);
  end

  // One register beat; the item channel idles meanwhile
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    in_ch.valid <= 0;
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, d);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic act, input logic [10:0] r, input bit steady);
    while (!steady && $urandom_range(99) < 16) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.action <= act; in_ch.row <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(act, r);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Lower-half row of the current height, sometimes at the edges; the height itself if there is none
  function automatic logic [10:0] good_row();
    int unsigned h, lo;
    h = sb.height;
    lo = h / 2 + 1;
    if (lo >= h) return 11'(h);
    case ($urandom_range(3))
      0: return 11'(lo);
      1: return 11'(h - 1);
      default: return 11'($urandom_range(h - 1, lo));
    endcase
  endfunction

  task automatic random_camera();
    write_reg(fctc_pkg::REG_CAM_X, $urandom());
    write_reg(fctc_pkg::REG_CAM_Y, $urandom());
    write_reg(fctc_pkg::REG_DIR_X, $urandom());
    write_reg(fctc_pkg::REG_DIR_Y, $urandom());
    write_reg(fctc_pkg::REG_PLANE_X, $urandom());
    write_reg(fctc_pkg::REG_PLANE_Y, $urandom());
  endtask

  initial begin
    int sent, n, k;
    logic [31:0] wd;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset geometry, typical camera, short row
    write_reg(fctc_pkg::REG_DIR_X, 32'h0000_4000);
    write_reg(fctc_pkg::REG_PLANE_Y, 32'h0000_2A3D);
    write_reg(fctc_pkg::REG_WIDTH, 8);
    send_item(ACT_PIX, 0, 1);           // excess step, no row
    send_item(ACT_ROW, 240, 1);         // middle row is invalid
    send_item(ACT_ROW, 480, 1);         // row at height invalid
    send_item(ACT_ROW, 2047, 1);
    send_item(ACT_ROW, 479, 1);
    for (k = 0; k < 10; k++) send_item(ACT_PIX, 11'($urandom()), 1);
    send_item(ACT_ROW, 241, 1);
    send_item(ACT_PIX, 0, 1);
    send_item(ACT_ROW, 100, 1);         // invalid, row goes on
    send_item(ACT_PIX, 0, 1);
    drain();
    // Extremes of the camera, zero width, smallest height with a lower-half row, then width 1 at height 2048
    write_reg(fctc_pkg::REG_CAM_X, 32'h7FFF_FFFF);
    write_reg(fctc_pkg::REG_CAM_Y, 32'h8000_0000);
    write_reg(fctc_pkg::REG_DIR_X, 32'h0000_7FFF);
    write_reg(fctc_pkg::REG_DIR_Y, 32'h0000_8000);
    write_reg(fctc_pkg::REG_PLANE_X, 32'h0000_8000);
    write_reg(fctc_pkg::REG_PLANE_Y, 32'h0000_7FFF);
    write_reg(fctc_pkg::REG_WIDTH, 0);
    write_reg(fctc_pkg::REG_HEIGHT, 3);
    send_item(ACT_ROW, 2, 1);
    send_item(ACT_PIX, 0, 1);
    write_reg(fctc_pkg::REG_WIDTH, 1);
    write_reg(fctc_pkg::REG_HEIGHT, 2048);
    send_item(ACT_ROW, 2047, 1);
    send_item(ACT_PIX, 0, 1);
    send_item(ACT_PIX, 0, 1);
    drain();

    // Random phases: mostly rows followed by pixel runs, with stray items
    sent = 0;
    while (sent < 1150) begin
      random_camera();
      case ($urandom_range(5))
        0: wd = 2048;
        1: wd = 1;
        default: wd = $urandom_range(24, 2);
      endcase
      write_reg(fctc_pkg::REG_WIDTH, wd);
      case ($urandom_range(4))
        0: wd = 2;
        1: wd = 2048;
        default: wd = $urandom_range(600, 3);
      endcase
      write_reg(fctc_pkg::REG_HEIGHT, wd);
      out_steady = (sent > 500 && sent < 650);
      for (n = 0; n < 6 && sent < 1150; n++) begin
        if ($urandom_range(9) == 0) begin
          send_item(ACT_ROW, 11'($urandom()), out_steady);
        end else begin
          send_item(ACT_ROW, good_row(), out_steady);
        end
        sent++;
        k = (sb.width > 30) ? $urandom_range(30) : sb.width + $urandom_range(2);
        repeat (k) begin
          send_item(ACT_PIX, 11'($urandom()), out_steady);
          sent++;
        end
        if ($urandom_range(4) == 0) begin
          // sender holds off until the block has delivered everything
          in_ch.valid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    out_steady = 0;

    if (errors == 0 && sb.pending.size() == 0) begin
      $display("floor_ceiling_texel_caster_tb passed");
    end else begin
      $display("floor_ceiling_texel_caster_tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/fctc_pkg.sv
rtl/core/fctc_if.sv
rtl/core/fctc_datapath.sv
rtl/core/fctc_ctrl.sv
rtl/core/floor_ceiling_texel_caster.sv
sim/floor_ceiling_texel_caster_tb.sv
